>>> rtl/cbt_pkg.sv
// Shared types and constants for the channel binding table.
`timescale 1ns / 1ps
package cbt_pkg;

  localparam int ENTRIES       = 16;
  localparam int ENDPOINT_BITS = 48;
  localparam int IDX_W         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W         = $clog2(ENTRIES + 1);
  localparam int CHAN_W        = 16;
  localparam int LIFE_W        = 16;
  localparam logic [LIFE_W-1:0] LIFETIME_RESET = LIFE_W'(600);

  typedef enum logic [2:0] {
    CMD_BIND  = 3'd0,
    CMD_CHECK = 3'd1,
    CMD_EP    = 3'd2,
    CMD_REV   = 3'd3,
    CMD_TICK  = 3'd4
  } cbt_cmd_e;

  typedef enum logic [2:0] {
    OP_BIND,
    OP_CHECK,
    OP_EP,
    OP_REV,
    OP_TICK,
    OP_BAD
  } cbt_op_e;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_OTHER_PEER     = 3'd1,
    ST_PEER_ELSEWHERE = 3'd2,
    ST_FULL           = 3'd3,
    ST_NOT_FOUND      = 3'd4
  } cbt_status_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DONE
  } cbt_state_e;

  typedef struct packed {
    cbt_op_e                  op;
    logic [CHAN_W-1:0]        channel;
    logic [ENDPOINT_BITS-1:0] endpoint;
  } cbt_item_t;

endpackage

>>> rtl/cbt_front.sv
// Front end: accepts items, decodes the command and queues them for the scan engine.
`timescale 1ns / 1ps
module cbt_front import cbt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        cmd_i,
  input  logic [CHAN_W-1:0] channel_i,
  input  logic [47:0]       peer_endpoint_i,
  output logic              q_valid_o,
  output cbt_item_t         q_item_o,
  input  logic              q_pop_i
);

  cbt_item_t  slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;
  cbt_item_t  item_in;

  always_comb begin
    unique case (cmd_i)
      CMD_BIND:  item_in.op = OP_BIND;
      CMD_CHECK: item_in.op = OP_CHECK;
      CMD_EP:    item_in.op = OP_EP;
      CMD_REV:   item_in.op = OP_REV;
      CMD_TICK:  item_in.op = OP_TICK;
      default:   item_in.op = OP_BAD;
    endcase
    item_in.channel  = channel_i;
    item_in.endpoint = peer_endpoint_i[ENDPOINT_BITS-1:0];
  end

  assign full      = (cnt_q == 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = slot_q[rd_ptr_q];
  assign do_push   = push && !full;
  assign do_pop    = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

>>> rtl/cbt_back.sv
// Back end: scans the binding table one entry per cycle and produces the result item.
`timescale 1ns / 1ps
module cbt_back import cbt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  input  cbt_item_t                q_item_i,
  output logic                     q_pop_o,
  input  logic                     lifetime_ticks_we_i,
  input  logic [LIFE_W-1:0]        lifetime_ticks_i,
  output logic                     empty,
  input  logic                     pop,
  output logic [2:0]               status_o,
  output logic                     found_o,
  output logic [CHAN_W-1:0]        channel_out_o,
  output logic [47:0]              endpoint_out_o
);

  logic [CHAN_W-1:0]        ch_mem  [ENTRIES];
  logic [ENDPOINT_BITS-1:0] ep_mem  [ENTRIES];
  logic [LIFE_W-1:0]        rem_mem [ENTRIES];

  logic [ENTRIES-1:0]       valid_q, valid_d;
  logic [LIFE_W-1:0]        lifetime_q;
  cbt_state_e               state_q, state_d;
  cbt_item_t                cur_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     issue;
  logic [IDX_W-1:0]         raddr;

  logic                     chk_v_q;
  logic [IDX_W-1:0]         chk_idx_q;
  logic [CHAN_W-1:0]        rd_ch_q;
  logic [ENDPOINT_BITS-1:0] rd_ep_q;
  logic [LIFE_W-1:0]        rd_rem_q;

  logic                     ch_hit_q, ch_eq_q, pe_hit_q, free_hit_q;
  logic [IDX_W-1:0]         ch_idx_q, free_idx_q;
  logic [ENDPOINT_BITS-1:0] ch_ep_q;
  logic [CHAN_W-1:0]        pe_ch_q;

  logic                     chk_vld, ch_m, pe_m;
  logic                     finish;
  logic                     we_rem, we_key;
  logic [IDX_W-1:0]         waddr;
  logic [LIFE_W-1:0]        wrem;

  logic                     out_v_q;
  cbt_status_e              res_status;
  logic                     res_found;
  logic [CHAN_W-1:0]        res_ch;
  logic [47:0]              res_ep;
  cbt_status_e              status_q;
  logic                     found_q;
  logic [CHAN_W-1:0]        ch_out_q;
  logic [47:0]              ep_out_q;

  assign raddr   = cnt_q[IDX_W-1:0];
  assign chk_vld = chk_v_q && valid_q[chk_idx_q];
  assign ch_m    = chk_vld && (rd_ch_q == cur_q.channel);
  assign pe_m    = chk_vld && (rd_ep_q == cur_q.endpoint);
  assign finish  = (state_q == B_DONE) && (!out_v_q || pop);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          state_d = (q_item_i.op == OP_BAD) ? B_DONE : B_SCAN;
        end
      end
      B_SCAN: begin
        if (cnt_q == CNT_W'(ENTRIES)) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (finish) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o    = (state_q == B_IDLE) && q_valid_i;
    issue      = (state_q == B_SCAN) && (cnt_q < CNT_W'(ENTRIES));
    we_rem     = 1'b0;
    we_key     = 1'b0;
    waddr      = chk_idx_q;
    wrem       = rd_rem_q - LIFE_W'(1);
    valid_d    = valid_q;
    res_status = ST_NOT_FOUND;
    res_found  = 1'b0;
    res_ch     = '0;
    res_ep     = '0;
    if ((state_q == B_SCAN) && (cur_q.op == OP_TICK) && chk_vld) begin
      if (rd_rem_q <= LIFE_W'(1)) begin
        valid_d[chk_idx_q] = 1'b0;
      end else begin
        we_rem = 1'b1;
      end
    end
    if (state_q == B_DONE) begin
      unique case (cur_q.op)
        OP_BIND: begin
          priority if (ch_hit_q) begin
            if (ch_eq_q) begin
              res_status = ST_OK;
              res_found  = 1'b1;
              we_rem     = finish;
              waddr      = ch_idx_q;
              wrem       = lifetime_q;
            end else begin
              res_status = ST_OTHER_PEER;
            end
          end else if (pe_hit_q) begin
            res_status = ST_PEER_ELSEWHERE;
          end else if (!free_hit_q) begin
            res_status = ST_FULL;
          end else begin
            res_status = ST_OK;
            res_found  = 1'b1;
            we_rem     = finish;
            we_key     = finish;
            waddr      = free_idx_q;
            wrem       = lifetime_q;
            if (finish) begin
              valid_d[free_idx_q] = 1'b1;
            end
          end
        end
        OP_CHECK, OP_EP: begin
          if (ch_hit_q) begin
            res_status = ST_OK;
            res_found  = 1'b1;
            if (cur_q.op == OP_EP) begin
              res_ep = ch_ep_q;
            end
          end
        end
        OP_REV: begin
          if (pe_hit_q) begin
            res_status = ST_OK;
            res_found  = 1'b1;
            res_ch     = pe_ch_q;
          end
        end
        OP_TICK: res_status = ST_OK;
        default: res_status = ST_NOT_FOUND;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_IDLE;
      valid_q    <= '0;
      lifetime_q <= LIFETIME_RESET;
      cnt_q      <= '0;
      chk_v_q    <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      chk_v_q <= issue;
      if (lifetime_ticks_we_i) begin
        lifetime_q <= (lifetime_ticks_i == '0) ? LIFE_W'(1) : lifetime_ticks_i;
      end
      if (q_pop_o) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (finish) begin
        out_v_q <= 1'b1;
      end else if (pop) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q      <= q_item_i;
      ch_hit_q   <= 1'b0;
      pe_hit_q   <= 1'b0;
      free_hit_q <= 1'b0;
    end
    if (issue) begin
      rd_ch_q   <= ch_mem[raddr];
      rd_ep_q   <= ep_mem[raddr];
      rd_rem_q  <= rem_mem[raddr];
      chk_idx_q <= raddr;
    end
    if ((state_q == B_SCAN) && chk_v_q) begin
      if (ch_m && !ch_hit_q) begin
        ch_hit_q <= 1'b1;
        ch_idx_q <= chk_idx_q;
        ch_eq_q  <= (rd_ep_q == cur_q.endpoint);
        ch_ep_q  <= rd_ep_q;
      end
      if (pe_m && !pe_hit_q) begin
        pe_hit_q <= 1'b1;
        pe_ch_q  <= rd_ch_q;
      end
      if (!chk_vld && !free_hit_q) begin
        free_hit_q <= 1'b1;
        free_idx_q <= chk_idx_q;
      end
    end
    if (we_rem) begin
      rem_mem[waddr] <= wrem;
    end
    if (we_key) begin
      ch_mem[waddr] <= cur_q.channel;
      ep_mem[waddr] <= cur_q.endpoint;
    end
    if (finish) begin
      status_q <= res_status;
      found_q  <= res_found;
      ch_out_q <= res_ch;
      ep_out_q <= res_ep;
    end
  end

  assign empty          = !out_v_q;
  assign status_o       = status_q;
  assign found_o        = found_q;
  assign channel_out_o  = ch_out_q;
  assign endpoint_out_o = ep_out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_SCAN |-> cnt_q <= CNT_W'(ENTRIES))
    else $error("scan counter past table end");

  a_insert_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_key |-> !valid_q[waddr])
    else $error("insert over a live entry");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish && res_found |-> res_status == ST_OK)
    else $error("found with non-ok status");

  a_chk_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_v_q |-> $past(state_q == B_SCAN))
    else $error("entry read outside a scan");

endmodule

>>> rtl/channel_binding_table_unit.sv
// Channel binding table: top level joining the decode queue and the scan engine.
// Each accepted item is scanned against the whole table before its result is produced.
// The table scan runs one entry per cycle through a single memory read port; the
// engine finishes one item before it pops the next, and unknown commands skip the scan.
// Input queue holds two items; a finished result waits in an output register.
// Reset (asynchronous, active low) clears all bindings and sets the lifetime to 600.
`timescale 1ns / 1ps
module channel_binding_table_unit import cbt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        cmd_i,
  input  logic [CHAN_W-1:0] channel_i,
  input  logic [47:0]       peer_endpoint_i,
  input  logic              lifetime_ticks_we_i,
  input  logic [LIFE_W-1:0] lifetime_ticks_i,
  output logic              empty,
  input  logic              pop,
  output logic [2:0]        status_o,
  output logic              found_o,
  output logic [CHAN_W-1:0] channel_out_o,
  output logic [47:0]       endpoint_out_o
);

  logic      q_valid;
  logic      q_pop;
  cbt_item_t q_item;

  cbt_front u_front (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .cmd_i,
    .channel_i,
    .peer_endpoint_i,
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  cbt_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .lifetime_ticks_we_i,
    .lifetime_ticks_i,
    .empty,
    .pop,
    .status_o,
    .found_o,
    .channel_out_o,
    .endpoint_out_o
  );

endmodule

>>> test/channel_binding_table_unit_tb.sv
// Randomized queue-driven testbench for channel_binding_table_unit with a scoreboard.
`timescale 1ns / 1ps

import cbt_pkg::*;

typedef struct packed {
  cbt_status_e              status;
  logic                     found;
  logic [CHAN_W-1:0]        channel;
  logic [ENDPOINT_BITS-1:0] endpoint;
} binding_reply_t;

class binding_table_mirror;
  bit                       live[ENTRIES];
  logic [CHAN_W-1:0]        chan[ENTRIES];
  logic [ENDPOINT_BITS-1:0] peer[ENTRIES];
  logic [LIFE_W-1:0]        ttl[ENTRIES];
  logic [LIFE_W-1:0]        lifetime;
  binding_reply_t           replies_due[$];
  int                       errors;

  function new();
    foreach (live[i]) begin
      live[i] = 1'b0;
      chan[i] = '0;
      peer[i] = '0;
      ttl[i]  = '0;
    end
    lifetime = LIFETIME_RESET;
    errors   = 0;
  endfunction

  function void set_lifetime(logic [LIFE_W-1:0] v);
    lifetime = (v == '0) ? LIFE_W'(1) : v;
  endfunction

  function int slot_of_channel(logic [CHAN_W-1:0] ch);
    for (int i = 0; i < ENTRIES; i++)
      if (live[i] && chan[i] == ch) return i;
    return -1;
  endfunction

  function int slot_of_peer(logic [ENDPOINT_BITS-1:0] ep);
    for (int i = 0; i < ENTRIES; i++)
      if (live[i] && peer[i] == ep) return i;
    return -1;
  endfunction

  function void take_request(logic [2:0] cmd, logic [CHAN_W-1:0] ch,
                             logic [ENDPOINT_BITS-1:0] ep);
    binding_reply_t r;
    int             k;
    int             slot;
    r = '{status: ST_NOT_FOUND, found: 1'b0, channel: '0, endpoint: '0};
    case (cmd)
      CMD_BIND: begin
        k = slot_of_channel(ch);
        if (k >= 0) begin
          if (peer[k] != ep) begin
            r.status = ST_OTHER_PEER;
          end else begin
            ttl[k]   = lifetime;
            r.status = ST_OK;
            r.found  = 1'b1;
          end
        end else if (slot_of_peer(ep) >= 0) begin
          r.status = ST_PEER_ELSEWHERE;
        end else begin
          slot = -1;
          for (int i = ENTRIES - 1; i >= 0; i--)
            if (!live[i]) slot = i;
          if (slot < 0) begin
            r.status = ST_FULL;
          end else begin
            live[slot] = 1'b1;
            chan[slot] = ch;
            peer[slot] = ep;
            ttl[slot]  = lifetime;
            r.status   = ST_OK;
            r.found    = 1'b1;
          end
        end
      end
      CMD_CHECK: begin
        if (slot_of_channel(ch) >= 0) begin
          r.status = ST_OK;
          r.found  = 1'b1;
        end
      end
      CMD_EP: begin
        k = slot_of_channel(ch);
        if (k >= 0) begin
          r.status   = ST_OK;
          r.found    = 1'b1;
          r.endpoint = peer[k];
        end
      end
      CMD_REV: begin
        k = slot_of_peer(ep);
        if (k >= 0) begin
          r.status  = ST_OK;
          r.found   = 1'b1;
          r.channel = chan[k];
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (live[i]) begin
            if (ttl[i] <= 1) begin
              ttl[i]  = '0;
              live[i] = 1'b0;
            end else begin
              ttl[i] = ttl[i] - 1'b1;
            end
          end
        end
        r.status = ST_OK;
      end
      default: ;
    endcase
    replies_due.push_back(r);
  endfunction

  function void match_reply(logic [2:0] status, logic found, logic [CHAN_W-1:0] ch,
                            logic [47:0] ep);
    binding_reply_t e;
    if (replies_due.size() == 0) begin
      $error("result item with no item awaiting it");
      errors++;
      return;
    end
    e = replies_due.pop_front();
    if (status !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, status);
      errors++;
    end
    if (found !== e.found) begin
      $error("found: expected %0d, got %0d", e.found, found);
      errors++;
    end
    if (ch !== e.channel) begin
      $error("channel_out: expected %h, got %h", e.channel, ch);
      errors++;
    end
    if (ep !== e.endpoint) begin
      $error("endpoint_out: expected %h, got %h", e.endpoint, ep);
      errors++;
    end
  endfunction

  function int pending();
    return replies_due.size();
  endfunction
endclass

module channel_binding_table_unit_tb;

  localparam int          POOL      = 24;
  localparam int          PHASES    = 6;
  localparam int          PHASE_LEN = 205;
  localparam int          WATCHDOG  = 3000;
  localparam logic [2:0]  CMD_TOP   = '1;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [2:0]        cmd_i = CMD_TICK;
  logic [CHAN_W-1:0] channel_i = '0;
  logic [47:0]       peer_endpoint_i = '0;
  logic              lifetime_ticks_we_i = 1'b0;
  logic [LIFE_W-1:0] lifetime_ticks_i = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [2:0]        status_o;
  logic              found_o;
  logic [CHAN_W-1:0] channel_out_o;
  logic [47:0]       endpoint_out_o;

  binding_table_mirror mirror = new();

  logic [CHAN_W-1:0]        chan_pool[POOL];
  logic [ENDPOINT_BITS-1:0] peer_pool[POOL];
  bit                       no_idle = 1'b0;
  int                       pop_hold = 0;
  int                       quiet_cycles = 0;

  channel_binding_table_unit DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push                (push),
    .full                (full),
    .cmd_i               (cmd_i),
    .channel_i           (channel_i),
    .peer_endpoint_i     (peer_endpoint_i),
    .lifetime_ticks_we_i (lifetime_ticks_we_i),
    .lifetime_ticks_i    (lifetime_ticks_i),
    .empty               (empty),
    .pop                 (pop),
    .status_o            (status_o),
    .found_o             (found_o),
    .channel_out_o       (channel_out_o),
    .endpoint_out_o      (endpoint_out_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int draw_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [47:0] random_endpoint();
    return 48'({$urandom, $urandom});
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      mirror.match_reply(status_o, found_o, channel_out_o, endpoint_out_o);
      pop_hold = draw_gap();
    end
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold = pop_hold - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(logic [2:0] cmd, logic [CHAN_W-1:0] ch, logic [47:0] ep);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push            <= 1'b1;
    cmd_i           <= cmd;
    channel_i       <= ch;
    peer_endpoint_i <= ep;
    do @(posedge clk_i); while (full !== 1'b0);
    mirror.take_request(cmd, ch, ep);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_lifetime(logic [LIFE_W-1:0] v);
    lifetime_ticks_we_i <= 1'b1;
    lifetime_ticks_i    <= v;
    @(posedge clk_i);
    mirror.set_lifetime(v);
    lifetime_ticks_we_i <= 1'b0;
  endtask

  task automatic fill_pools();
    chan_pool[0] = '0;
    chan_pool[1] = '1;
    peer_pool[0] = '0;
    peer_pool[1] = '1;
    for (int i = 2; i < POOL; i++) begin
      chan_pool[i] = 16'($urandom);
      peer_pool[i] = random_endpoint();
    end
  endtask

  task automatic random_item(int tick_pct);
    logic [2:0]        c;
    logic [CHAN_W-1:0] ch;
    logic [47:0]       ep;
    int                r;
    ch = chan_pool[$urandom_range(0, POOL - 1)];
    ep = peer_pool[$urandom_range(0, POOL - 1)];
    r  = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < tick_pct) c = CMD_TICK;
    else if (r < 45) c = CMD_BIND;
    else if (r < 60) c = CMD_CHECK;
    else if (r < 75) c = CMD_EP;
    else if (r < 90) c = CMD_REV;
    else begin
      c  = 3'($urandom_range(0, CMD_TOP));
      ch = 16'($urandom);
      ep = random_endpoint();
    end
    send_item(c, ch, ep);
  endtask

  initial begin
    logic [LIFE_W-1:0] lifetimes[PHASES];
    int                tick_pcts[PHASES];
    lifetimes = '{16'd0, 16'd1, 16'd5, 16'd0, 16'd600, 16'hFFFF};
    lifetimes[3] = 16'($urandom_range(2, 300));
    tick_pcts = '{10, 20, 8, 15, 3, 10};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    no_idle = 1'b1;
    send_item(CMD_BIND,  '0,       '0);
    send_item(CMD_BIND,  '1,       '1);
    send_item(CMD_BIND,  '0,       '0);
    send_item(CMD_BIND,  '0,       48'd1);
    send_item(CMD_BIND,  16'd5,    '1);
    no_idle = 1'b0;
    send_item(CMD_BIND,  16'h8000, 48'h8000_0000_0000);
    send_item(CMD_CHECK, '1,       random_endpoint());
    send_item(CMD_CHECK, 16'd5,    random_endpoint());
    send_item(CMD_EP,    '1,       random_endpoint());
    send_item(CMD_EP,    16'h1234, random_endpoint());
    send_item(CMD_REV,   16'($urandom), '1);
    send_item(CMD_REV,   16'($urandom), '0);
    send_item(CMD_REV,   16'($urandom), 48'h8000_0000_0001);
    send_item(CMD_TICK,  16'($urandom), random_endpoint());
    for (int c = CMD_TICK + 1; c <= CMD_TOP; c++)
      send_item(3'(c), 16'($urandom), random_endpoint());
    send_item(CMD_EP,    16'h8000, '0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_lifetime(lifetimes[p]);
      fill_pools();
      for (int n = 0; n < PHASE_LEN; n++) begin
        no_idle = (n < 30);
        random_item(tick_pcts[p]);
      end
    end
    no_idle = 1'b0;

    drain();
    repeat (30) @(posedge clk_i);
    if (mirror.errors == 0 && mirror.pending() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
